// File: rtl/core/cnlc_pkg.sv
package cnlc_pkg;

	localparam int unsigned MIN_DIGITS = 13;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;

	localparam logic [3:0] VISA_LEAD  = 4'd4;
	localparam logic [3:0] MC_LEAD    = 4'd5;
	localparam logic [3:0] MC_LOW     = 4'd1;
	localparam logic [3:0] MC_HIGH    = 4'd5;
	localparam logic [3:0] AMEX_LEAD  = 4'd3;
	localparam logic [3:0] AMEX_SEC_A = 4'd4;
	localparam logic [3:0] AMEX_SEC_B = 4'd7;

	// one accepted input beat
	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} char_beat_t;

	// Luhn doubling: 2*d with the digits of the product summed
	function automatic logic [3:0] luhn_double(input logic [3:0] d);
		logic [3:0] r;
		unique case (d)
			4'd0:    r = 4'd0;
			4'd1:    r = 4'd2;
			4'd2:    r = 4'd4;
			4'd3:    r = 4'd6;
			4'd4:    r = 4'd8;
			4'd5:    r = 4'd1;
			4'd6:    r = 4'd3;
			4'd7:    r = 4'd5;
			4'd8:    r = 4'd7;
			4'd9:    r = 4'd9;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] add_mod10(input logic [3:0] a, input logic [3:0] b);
		logic [4:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= 5'd10) ? 4'(s - 5'd10) : s[3:0];
	endfunction

	function automatic logic prefix_ok(input logic [3:0] d1, input logic [3:0] d2);
		logic ok;
		priority if (d1 == VISA_LEAD)
			ok = 1'b1;
		else if (d1 == MC_LEAD)
			ok = (d2 >= MC_LOW) && (d2 <= MC_HIGH);
		else if (d1 == AMEX_LEAD)
			ok = (d2 == AMEX_SEC_A) || (d2 == AMEX_SEC_B);
		else
			ok = 1'b0;
		return ok;
	endfunction

endpackage

// File: rtl/core/card_number_luhn_checker.sv
// The final character is held in the input register; the verdict registers as it leaves.
// Throughput: one character per cycle, limited by the state update
// behind the input register; the input stalls only while a verdict waits at the output.
// Reset (arst_n low, asynchronous): pipeline empty, no verdict pending, count and
// sums cleared. The running state also returns to reset after each final character.
module card_number_luhn_checker
	import cnlc_pkg::*;
#(
	parameter int unsigned MAX_DIGITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       card_valid
);

	char_beat_t beat_s1;
	logic       valid_s1;
	logic       go_s1;
	logic       out_free;
	logic       char_take;
	logic       verdict;
	logic       res_valid_q;
	logic       card_valid_q;

	assign out_free   = !res_valid_q || !result_stall;
	assign go_s1      = valid_s1 && (!beat_s1.last || out_free);
	assign char_stall = valid_s1 && !go_s1;
	assign char_take  = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= char_take || (valid_s1 && !go_s1);
	end

	always_ff @(posedge clk) begin
		if (char_take)
			beat_s1 <= '{code: char_code, last: last_char};
	end

	cnlc_accum #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (go_s1),
		.beat   (beat_s1),
		.verdict(verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (go_s1 && beat_s1.last)
			res_valid_q <= 1'b1;
		else if (!result_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (go_s1 && beat_s1.last)
			card_valid_q <= verdict;
	end

	assign result_valid = res_valid_q;
	assign card_valid   = card_valid_q;

	stall_cause_a: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> valid_s1 && beat_s1.last && res_valid_q && result_stall)
		else $error("input stalled without a blocked verdict");

	verdict_out_a: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && beat_s1.last |=> res_valid_q)
		else $error("final character produced no verdict beat");

	mid_flow_a: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !beat_s1.last |-> !char_stall)
		else $error("stall on a non-final character");

endmodule

// File: rtl/core/cnlc_accum.sv
module cnlc_accum
	import cnlc_pkg::*;
#(
	parameter int unsigned MAX_DIGITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  char_beat_t beat,
	output logic       verdict
);

	localparam int unsigned CNT_SAT = MAX_DIGITS + 1;
	localparam int unsigned CW      = $clog2(MAX_DIGITS + 2);

	logic [CW-1:0] count_q, count_nx;
	logic          all_digits_q, all_digits_nx;
	logic [3:0]    first_q, first_nx;
	logic [3:0]    second_q, second_nx;
	logic [3:0]    sum_odd_q, sum_odd_nx;
	logic [3:0]    sum_even_q, sum_even_nx;
	logic          is_digit;
	logic [3:0]    digit;
	logic [3:0]    digit_dbl;
	logic [3:0]    sel_sum;
	logic          len_ok;

	assign is_digit  = (beat.code >= ASCII_ZERO) && (beat.code <= ASCII_NINE);
	assign digit     = is_digit ? beat.code[3:0] : 4'd0;
	assign digit_dbl = luhn_double(digit);

	always_comb begin
		all_digits_nx = all_digits_q & is_digit;
		first_nx      = (count_q == CW'(0)) ? digit : first_q;
		second_nx     = (count_q == CW'(1)) ? digit : second_q;
		// even position is doubled if the final length turns out even
		if (!count_q[0]) begin
			sum_even_nx = add_mod10(sum_even_q, digit_dbl);
			sum_odd_nx  = add_mod10(sum_odd_q, digit);
		end else begin
			sum_even_nx = add_mod10(sum_even_q, digit);
			sum_odd_nx  = add_mod10(sum_odd_q, digit_dbl);
		end
		count_nx = (count_q == CW'(CNT_SAT)) ? count_q : count_q + CW'(1);
	end

	assign sel_sum = count_nx[0] ? sum_odd_nx : sum_even_nx;
	assign len_ok  = (count_nx >= CW'(MIN_DIGITS)) && (count_nx <= CW'(MAX_DIGITS));
	assign verdict = len_ok && all_digits_nx && prefix_ok(first_nx, second_nx)
		&& (sel_sum == 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			all_digits_q <= 1'b1;
			first_q      <= '0;
			second_q     <= '0;
			sum_odd_q    <= '0;
			sum_even_q   <= '0;
		end else if (en) begin
			if (beat.last) begin
				count_q      <= '0;
				all_digits_q <= 1'b1;
				first_q      <= '0;
				second_q     <= '0;
				sum_odd_q    <= '0;
				sum_even_q   <= '0;
			end else begin
				count_q      <= count_nx;
				all_digits_q <= all_digits_nx;
				first_q      <= first_nx;
				second_q     <= second_nx;
				sum_odd_q    <= sum_odd_nx;
				sum_even_q   <= sum_even_nx;
			end
		end
	end

	cnt_sat_a: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CNT_SAT))
		else $error("character count above saturation");

	last_clears_a: assert property (@(posedge clk) disable iff (!arst_n)
		en && beat.last |=> count_q == '0 && all_digits_q)
		else $error("state not cleared after final character");

	sums_range_a: assert property (@(posedge clk) disable iff (!arst_n)
		sum_odd_q <= 4'd9 && sum_even_q <= 4'd9)
		else $error("Luhn sum out of mod-10 range");

endmodule
